@@ rtl/pnc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, register indexes, action codes and datapath operation codes
package pnc_pkg;

    localparam int NOW_W      = 32;
    localparam int POS_W      = 23;
    localparam int ERR_W      = 16;
    localparam int DB_W       = 10;
    localparam int KP_W       = 16;
    localparam int KI_W       = 32;
    localparam int PER_W      = 16;
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 56;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OP_W       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_HZ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERCENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERCENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 3'd6;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_MOVE = 2'd2;

    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_FIRST  = 4'd2;
    localparam logic [OP_W-1:0] OP_SKIP   = 4'd3;
    localparam logic [OP_W-1:0] OP_STOP   = 4'd4;
    localparam logic [OP_W-1:0] OP_START  = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_DT = 4'd6;
    localparam logic [OP_W-1:0] OP_ACC    = 4'd7;
    localparam logic [OP_W-1:0] OP_MAG    = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_MUL_HI = 4'd10;
    localparam logic [OP_W-1:0] OP_ITERM  = 4'd11;
    localparam logic [OP_W-1:0] OP_NUDGE  = 4'd12;
    localparam logic [OP_W-1:0] OP_TARGET = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT   = 4'd14;

    typedef struct packed {
        logic [KP_W-1:0]  kp_gain;
        logic [KI_W-1:0]  ki_gain;
        logic [DB_W-1:0]  deadband_hz;
        logic [POS_W-1:0] min_percent;
        logic [POS_W-1:0] max_percent;
        logic [PER_W-1:0] period_ms;
        logic             invert_direction;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic due;
        logic flags_ok;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/pnc_cfg_regs.sv @@
`timescale 1ns / 1ps
// configuration register bank with reset defaults
module pnc_cfg_regs
    import pnc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_KP_GAIN:     cfg_next.kp_gain          = cfg_wdata[KP_W-1:0];
                REG_KI_GAIN:     cfg_next.ki_gain          = cfg_wdata[KI_W-1:0];
                REG_DEADBAND_HZ: cfg_next.deadband_hz      = cfg_wdata[DB_W-1:0];
                REG_MIN_PERCENT: cfg_next.min_percent      = cfg_wdata[POS_W-1:0];
                REG_MAX_PERCENT: cfg_next.max_percent      = cfg_wdata[POS_W-1:0];
                REG_PERIOD_MS:   cfg_next.period_ms        = cfg_wdata[PER_W-1:0];
                REG_INVERT:      cfg_next.invert_direction = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain          <= 16'd3277;
            cfg_reg.ki_gain          <= 32'd429;
            cfg_reg.deadband_hz      <= 10'd2;
            cfg_reg.min_percent      <= 23'd0;
            cfg_reg.max_percent      <= 23'd6553600;
            cfg_reg.period_ms        <= 16'd20;
            cfg_reg.invert_direction <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pnc_datapath.sv @@
`timescale 1ns / 1ps
// controller datapath: timing, integral, shared multiplier, target and output register
module pnc_datapath
    import pnc_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = 40
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam logic signed [66:0] INT_MAX =
        $signed({{(68-INTEGRAL_WIDTH){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}});
    localparam logic signed [66:0] INT_MIN = -INT_MAX - 67'sd1;
    localparam logic signed [53:0] NUDGE_MAX = 54'sd2147483647;
    localparam logic signed [53:0] NUDGE_MIN = -54'sd2147483648;

    // beat and loop state
    logic [NOW_W-1:0]               now_reg,      now_next;
    logic [POS_W-1:0]               pos_reg,      pos_next;
    logic                           tv_reg,       tv_next;
    logic                           ev_reg,       ev_next;
    logic signed [ERR_W-1:0]        err_reg,      err_next;
    logic [NOW_W-1:0]               dt_reg,       dt_next;
    logic [NOW_W-1:0]               last_reg,     last_next;
    logic                           started_reg,  started_next;
    logic                           running_reg,  running_next;
    logic [POS_W-1:0]               target_reg,   target_next;
    logic signed [INTEGRAL_WIDTH-1:0] integral_reg, integral_next;
    // arithmetic pipeline
    logic signed [65:0]             prod_reg,     prod_next;
    logic [63:0]                    p0_reg,       p0_next;
    logic signed [33:0]             pterm_reg,    pterm_next;
    logic [63:0]                    mag_reg,      mag_next;
    logic                           neg_reg,      neg_next;
    logic signed [51:0]             iterm_reg,    iterm_next;
    logic signed [53:0]             nudge_reg,    nudge_next;
    logic [1:0]                     action_reg,   action_next;
    // output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]           m_tdata_reg,  m_tdata_next;
    logic [M_TUSER_W-1:0]           m_tuser_reg,  m_tuser_next;

    logic [NOW_W-1:0]   dt;
    logic signed [16:0] err_wide;
    logic signed [16:0] db_wide;
    logic               in_deadband;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [66:0] isum;
    logic signed [64:0] iext;
    logic signed [64:0] imag;
    logic [50:0]        iterm_mag;
    logic signed [52:0] nsum;
    logic signed [55:0] tsum;
    logic               t_out;
    logic [31:0]        nudge_sat;

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [55:0] v,
                                                   input logic [POS_W-1:0] lo,
                                                   input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] r;
        if (v < $signed({33'd0, lo}))
            r = lo;
        else if (v > $signed({33'd0, hi}))
            r = hi;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    assign dt           = now_reg - last_reg;
    assign sts.started  = started_reg;
    assign sts.due      = dt >= {16'd0, cfg.period_ms};
    assign sts.flags_ok = tv_reg & ev_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign err_wide    = {err_reg[ERR_W-1], err_reg};
    assign db_wide     = $signed({7'd0, cfg.deadband_hz});
    assign in_deadband = (err_wide > -db_wide) && (err_wide < db_wide);

    // shared multiplier operand selection
    always_comb begin
        case (cmd.op)
            OP_MUL_DT: begin
                mul_a = {{17{err_reg[ERR_W-1]}}, err_reg};
                mul_b = $signed({1'b0, dt_reg});
            end
            OP_ACC: begin
                mul_a = {{17{err_reg[ERR_W-1]}}, err_reg};
                mul_b = $signed({17'd0, cfg.kp_gain});
            end
            OP_MUL_LO: begin
                mul_a = $signed({1'b0, cfg.ki_gain});
                mul_b = $signed({1'b0, mag_reg[31:0]});
            end
            OP_MUL_HI: begin
                mul_a = $signed({1'b0, cfg.ki_gain});
                mul_b = $signed({1'b0, mag_reg[63:32]});
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign isum = {{(67-INTEGRAL_WIDTH){integral_reg[INTEGRAL_WIDTH-1]}}, integral_reg}
                + {prod_reg[65], prod_reg};
    assign iext = {{(65-INTEGRAL_WIDTH){integral_reg[INTEGRAL_WIDTH-1]}}, integral_reg};
    assign imag = integral_reg[INTEGRAL_WIDTH-1] ? -iext : iext;

    // integral term magnitude, capped when the upper partial product overflows
    always_comb begin
        if (|prod_reg[63:32])
            iterm_mag = 51'd1 << 50;
        else
            iterm_mag = {3'd0, prod_reg[31:0], 16'd0} + {3'd0, p0_reg[63:16]};
    end

    assign nsum  = {{19{pterm_reg[33]}}, pterm_reg} + {iterm_reg[51], iterm_reg};
    assign tsum  = $signed({33'd0, target_reg}) + {{2{nudge_reg[53]}}, nudge_reg};
    assign t_out = (tsum < $signed({33'd0, cfg.min_percent}))
                || (tsum > $signed({33'd0, cfg.max_percent}));

    always_comb begin
        if (nudge_reg > NUDGE_MAX)
            nudge_sat = 32'h7FFF_FFFF;
        else if (nudge_reg < NUDGE_MIN)
            nudge_sat = 32'h8000_0000;
        else
            nudge_sat = nudge_reg[31:0];
    end

    always_comb begin
        now_next      = now_reg;
        pos_next      = pos_reg;
        tv_next       = tv_reg;
        ev_next       = ev_reg;
        err_next      = err_reg;
        dt_next       = dt_reg;
        last_next     = last_reg;
        started_next  = started_reg;
        running_next  = running_reg;
        target_next   = target_reg;
        integral_next = integral_reg;
        prod_next     = prod_reg;
        p0_next       = p0_reg;
        pterm_next    = pterm_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        iterm_next    = iterm_reg;
        nudge_next    = nudge_reg;
        action_next   = action_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (cmd.op)
            OP_LOAD: begin
                now_next = s_tdata[31:0];
                pos_next = s_tdata[54:32];
                err_next = s_tdata[70:55];
                tv_next  = s_tuser[0];
                ev_next  = s_tuser[1];
            end
            OP_FIRST: begin
                last_next    = now_reg;
                started_next = 1'b1;
                target_next  = clamp_pos($signed({33'd0, pos_reg}),
                                         cfg.min_percent, cfg.max_percent);
                action_next  = ACT_NONE;
                nudge_next   = 54'sd0;
            end
            OP_SKIP: begin
                action_next = ACT_NONE;
                nudge_next  = 54'sd0;
            end
            OP_STOP: begin
                last_next     = now_reg;
                integral_next = '0;
                target_next   = clamp_pos($signed({33'd0, pos_reg}),
                                          cfg.min_percent, cfg.max_percent);
                running_next  = 1'b0;
                action_next   = ACT_STOP;
                nudge_next    = 54'sd0;
            end
            OP_START: begin
                last_next    = now_reg;
                dt_next      = dt;
                err_next     = in_deadband ? 16'sd0 : err_reg;
                running_next = 1'b1;
                action_next  = ACT_MOVE;
            end
            OP_MUL_DT: begin
                prod_next = mul_p;
            end
            OP_ACC: begin
                if (isum > INT_MAX)
                    integral_next = INT_MAX[INTEGRAL_WIDTH-1:0];
                else if (isum < INT_MIN)
                    integral_next = INT_MIN[INTEGRAL_WIDTH-1:0];
                else
                    integral_next = isum[INTEGRAL_WIDTH-1:0];
                prod_next = mul_p;
            end
            OP_MAG: begin
                pterm_next = prod_reg[33:0];
                mag_next   = imag[63:0];
                neg_next   = integral_reg[INTEGRAL_WIDTH-1];
            end
            OP_MUL_LO: begin
                prod_next = mul_p;
            end
            OP_MUL_HI: begin
                p0_next   = prod_reg[63:0];
                prod_next = mul_p;
            end
            OP_ITERM: begin
                iterm_next = neg_reg ? -$signed({1'b0, iterm_mag})
                                     : $signed({1'b0, iterm_mag});
            end
            OP_NUDGE: begin
                nudge_next = cfg.invert_direction ? -{nsum[52], nsum} : {nsum[52], nsum};
            end
            OP_TARGET: begin
                if (t_out) begin
                    target_next   = clamp_pos(tsum, cfg.min_percent, cfg.max_percent);
                    integral_next = '0;
                end else begin
                    target_next = tsum[POS_W-1:0];
                end
            end
            OP_EMIT: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {running_reg, nudge_sat, target_reg};
                m_tuser_next  = action_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg     <= '0;
            started_reg  <= 1'b0;
            running_reg  <= 1'b0;
            target_reg   <= '0;
            integral_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            last_reg     <= last_next;
            started_reg  <= started_next;
            running_reg  <= running_next;
            target_reg   <= target_next;
            integral_reg <= integral_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        pos_reg     <= pos_next;
        tv_reg      <= tv_next;
        ev_reg      <= ev_next;
        err_reg     <= err_next;
        dt_reg      <= dt_next;
        prod_reg    <= prod_next;
        p0_reg      <= p0_next;
        pterm_reg   <= pterm_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        iterm_reg   <= iterm_next;
        nudge_reg   <= nudge_next;
        action_reg  <= action_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken beat");

    a_target_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_TARGET && cfg.min_percent <= cfg.max_percent)
        |=> (target_reg >= cfg.min_percent && target_reg <= cfg.max_percent))
        else $error("target left the limits after update");

    a_stop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == ACT_STOP)
        |-> (m_tdata_reg[54:23] == 32'd0 && !m_tdata_reg[55]))
        else $error("stop beat with nonzero nudge or active loop");

endmodule

@@ rtl/pnc_controller.sv @@
`timescale 1ns / 1ps
// sequencing state machine for one control update
module pnc_controller
    import pnc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EVAL   = 4'd1;
    localparam logic [3:0] ST_MUL_DT = 4'd2;
    localparam logic [3:0] ST_ACC    = 4'd3;
    localparam logic [3:0] ST_MAG    = 4'd4;
    localparam logic [3:0] ST_MUL_LO = 4'd5;
    localparam logic [3:0] ST_MUL_HI = 4'd6;
    localparam logic [3:0] ST_ITERM  = 4'd7;
    localparam logic [3:0] ST_NUDGE  = 4'd8;
    localparam logic [3:0] ST_TARGET = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!sts.started) begin
                    cmd.op     = OP_FIRST;
                    state_next = ST_OUT;
                end else if (!sts.due) begin
                    cmd.op     = OP_SKIP;
                    state_next = ST_OUT;
                end else if (!sts.flags_ok) begin
                    cmd.op     = OP_STOP;
                    state_next = ST_OUT;
                end else begin
                    cmd.op     = OP_START;
                    state_next = ST_MUL_DT;
                end
            end
            ST_MUL_DT: begin
                cmd.op     = OP_MUL_DT;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op     = OP_ACC;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                cmd.op     = OP_MAG;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_ITERM;
            end
            ST_ITERM: begin
                cmd.op     = OP_ITERM;
                state_next = ST_NUDGE;
            end
            ST_NUDGE: begin
                cmd.op     = OP_NUDGE;
                state_next = ST_TARGET;
            end
            ST_TARGET: begin
                cmd.op     = OP_TARGET;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EVAL)
        else $error("accepted beat not evaluated");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !sts.out_free) |=> state_reg == ST_OUT)
        else $error("result dropped while output busy");

endmodule

@@ rtl/pi_position_nudge_controller.sv @@
`timescale 1ns / 1ps
// top level of the pi position nudge controller
//
// One input beat gives exactly one result beat. The first beat after reset
// latches time and position; later beats before period_ms has elapsed
// report action none; a due beat with either validity flag low reports a
// stop; a due beat with both flags high runs the pi update and reports a
// move. The block takes one beat at a time: a beat that ends without a pi
// update passes through the idle, eval and out states, a pi update also
// through the steps around the single shared 33 x 33 multiplier (error times
// elapsed time, kp times error, then ki times the low and high halves of
// the integral magnitude). A finished result waits in the output register,
// so the next beat is taken while it waits; the block only holds off when
// a second result is ready and the first has still not been taken.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
module pi_position_nudge_controller
    import pnc_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = 40
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms [31:0], position_percent [54:32], pitch_error_hz [70:55], zero [71]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // target_valid [0], error_valid [1]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // target_out [22:0], nudge_out [54:23], loop_active [55]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // action [1:0]
    output logic [M_TUSER_W-1:0]  m_tuser
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    pnc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pnc_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pnc_datapath #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
